// ----- rtl/core/ped_pkg.sv -----
// Package for the pairwise Euclidean distance unit: fixed field widths,
// config register indexes and the result payload type. No dependencies.
package ped_pkg;
  localparam int unsigned DistWidth = 18;
  localparam int unsigned IdxWidth  = 6;
  localparam int unsigned CfgWidth  = 7;
  localparam int unsigned CfgIdxWidth = 1;
  localparam logic [CfgIdxWidth-1:0] RegNumPoints = 1'b0;
  localparam logic [CfgIdxWidth-1:0] RegNumDims   = 1'b1;

  typedef struct packed {
    logic [DistWidth-1:0] distance;
    logic [IdxWidth-1:0]  row_index;
    logic [IdxWidth-1:0]  col_index;
    logic                 last_of_run;
  } result_t;
endpackage

// ----- rtl/core/ped_stream_if.sv -----
// Valid/ready channel carrying a payload of type T.
// Depends on nothing.
interface ped_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/ped_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
module ped_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- rtl/core/ped_lane.sv -----
// One distance lane: registered squared difference of one coordinate,
// gated off when the lane is beyond num_dims. Depends on nothing.
module ped_lane #(
  parameter int unsigned CoordWidth = 16
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [CoordWidth-1:0] a_i,
  input  logic signed [CoordWidth-1:0] b_i,
  output logic [2*CoordWidth-1:0]      sq_o
);
  logic signed [CoordWidth:0] diff;
  logic [CoordWidth:0]        mag;
  logic [2*CoordWidth+1:0]    prod;
  assign diff = {a_i[CoordWidth-1], a_i} - {b_i[CoordWidth-1], b_i};
  assign mag  = diff[CoordWidth] ? (~diff + 1'b1) : diff;
  assign prod = mag * mag;
  always_ff @(posedge clk_i) begin
    sq_o <= en_i ? prod[2*CoordWidth-1:0] : '0;
  end
endmodule

// ----- rtl/core/ped_sqrt.sv -----
// Pipelined floor integer square root, one result bit per stage.
// Carries a tag of type T alongside. Depends on nothing.
module ped_sqrt #(
  parameter int unsigned InWidth = 35,
  parameter type T = logic
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [InWidth-1:0] x_i,
  input  T                   tag_i,
  output logic               valid_o,
  output logic [(InWidth+1)/2-1:0] root_o,
  output T                   tag_o
);
  localparam int unsigned RW = (InWidth + 1) / 2;
  localparam int unsigned XW = 2 * RW;
  logic [XW-1:0] rem_q  [RW+1];
  logic [RW-1:0] res_q  [RW+1];
  logic [RW:0]   vld_q;
  T              tag_q  [RW+1];

  always_comb begin
    rem_q[0] = XW'(x_i);
    res_q[0] = '0;
    tag_q[0] = tag_i;
  end
  assign vld_q[0] = valid_i;

  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int unsigned Sh = 2 * (RW - 1 - s);
    logic [XW-1:0] trial;
    logic          take;
    // compare the remainder against (4r+1) shifted into place
    assign trial = (XW'(res_q[s]) << (Sh + 2)) | (XW'(1) << Sh);
    assign take  = rem_q[s] >= trial;
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= take ? rem_q[s] - trial : rem_q[s];
      res_q[s+1] <= {res_q[s][RW-2:0], take};
      tag_q[s+1] <= tag_q[s];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[s+1] <= 1'b0;
      else         vld_q[s+1] <= vld_q[s];
    end
  end

  assign valid_o = vld_q[RW];
  assign root_o  = res_q[RW];
  assign tag_o   = tag_q[RW];
endmodule

// ----- rtl/core/pairwise_euclidean_distance_unit.sv -----
// Pairwise Euclidean distance unit. Each point stored at slot i yields i
// distances to slots 0..i-1, one per cycle through MaxDims parallel
// difference-square lanes, an adder tree and a pipelined root. A point in
// slot i > 0 holds the input while its i distances issue through the single
// read port of the point store, then while the three front stages and the
// RootW-stage root drain; slot 0 waits only for the drain set on accept.
// A stalled result side holds back issue once the output FIFO nears full.
// Depends on ped_pkg, ped_stream_if, ped_ram, ped_lane, ped_sqrt.
module pairwise_euclidean_distance_unit #(
  parameter int unsigned MaxPoints  = 64,
  parameter int unsigned MaxDims    = 8,
  parameter int unsigned CoordWidth = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  ped_stream_if.sink   in_if,
  ped_stream_if.source out_if,
  input  logic                                 cfg_we_i,
  input  logic [ped_pkg::CfgIdxWidth-1:0]      cfg_index_i,
  input  logic [ped_pkg::CfgWidth-1:0]         cfg_wdata_i
);
  import ped_pkg::*;
  localparam int unsigned PW = $clog2(MaxPoints);
  localparam int unsigned SqW = 2 * CoordWidth;
  localparam int unsigned SumW = SqW + $clog2(MaxDims + 1);
  localparam int unsigned RootW = (SumW + 1) / 2;
  localparam int unsigned FifoDepth = 32;
  localparam int unsigned FW = $clog2(FifoDepth);

  typedef struct packed {
    logic [IdxWidth-1:0] row;
    logic [IdxWidth-1:0] col;
    logic                last;
  } tag_t;

  logic [6:0] num_points_q;
  logic [3:0] num_dims_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= 7'd64;
      num_dims_q   <= 4'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegNumPoints: num_points_q <= cfg_wdata_i;
        RegNumDims:   num_dims_q   <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // sequencer
  logic          busy_q, busy_d;
  logic [PW-1:0] row_q, row_d, col_q, col_d, cnt_q, cnt_d;
  logic [7:0]    drain_q, drain_d;
  logic          acc;
  logic signed [CoordWidth-1:0] cur_q [MaxDims];

  logic [FW:0] fill_q;
  logic        issue;
  localparam int unsigned Lat = RootW + 3;

  assign in_if.ready = !busy_q && drain_q == '0;
  assign acc   = in_if.valid && in_if.ready;
  assign issue = busy_q && (fill_q + (FW+1)'(Lat) < (FW+1)'(FifoDepth));

  always_comb begin
    busy_d = busy_q; row_d = row_q; col_d = col_q; cnt_d = cnt_q;
    drain_d = (drain_q != '0) ? drain_q - 1'b1 : drain_q;
    if (acc) begin
      row_d = cnt_q;
      col_d = '0;
      busy_d = cnt_q != '0;
      if ({1'b0, cnt_q} + 8'd1 >= ((num_points_q > 7'(MaxPoints)) ? 8'(MaxPoints)
                                                              : {1'b0, num_points_q}))
        cnt_d = '0;
      else
        cnt_d = cnt_q + 1'b1;
      drain_d = 8'd2;
    end else if (issue) begin
      col_d = col_q + 1'b1;
      if (col_q + 1'b1 == row_q) begin
        busy_d = 1'b0;
        drain_d = 8'(Lat + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; row_q <= '0; col_q <= '0; cnt_q <= '0; drain_q <= '0;
    end else begin
      busy_q <= busy_d; row_q <= row_d; col_q <= col_d; cnt_q <= cnt_d;
      drain_q <= drain_d;
    end
  end

  // lanes: one RAM and one lane per coordinate
  logic [SqW-1:0] sq [MaxDims];
  logic           v1_q, v2_q;
  tag_t           t1_q, t2_q;
  for (genvar d = 0; d < MaxDims; d++) begin : g_lane
    logic [CoordWidth-1:0] rd;
    logic signed [CoordWidth-1:0] din;
    assign din = in_if.data[d*CoordWidth +: CoordWidth];
    always_ff @(posedge clk_i) if (acc) cur_q[d] <= din;
    ped_ram #(.Width(CoordWidth), .Depth(MaxPoints)) u_ram (
      .clk_i, .we_i(acc), .waddr_i(cnt_q), .wdata_i(din),
      .raddr_i(col_q), .rdata_o(rd)
    );
    ped_lane #(.CoordWidth(CoordWidth)) u_lane (
      .clk_i, .en_i(4'(d) < num_dims_q), .a_i(cur_q[d]), .b_i(rd), .sq_o(sq[d])
    );
  end

  // merge: sum the lanes
  logic [SumW-1:0] sum_q;
  logic            v3_q;
  tag_t            t3_q;
  always_ff @(posedge clk_i) begin
    logic [SumW-1:0] s;
    s = '0;
    for (int d = 0; d < MaxDims; d++) s = s + SumW'(sq[d]);
    sum_q <= s;
    t1_q <= '{row: IdxWidth'(row_q), col: IdxWidth'(col_q),
              last: (col_q + 1'b1 == row_q)};
    t2_q <= t1_q; t3_q <= t2_q;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; end
    else begin v1_q <= issue; v2_q <= v1_q; v3_q <= v2_q; end
  end

  logic             rv;
  logic [RootW-1:0] root;
  tag_t             rt;
  ped_sqrt #(.InWidth(SumW), .T(tag_t)) u_sqrt (
    .clk_i, .rst_ni, .valid_i(v3_q), .x_i(sum_q), .tag_i(t3_q),
    .valid_o(rv), .root_o(root), .tag_o(rt)
  );

  // output FIFO; the issue check above leaves room for every result in flight
  result_t     fifo_q [FifoDepth];
  logic [FW-1:0] wp_q, rp_q;
  logic        pop;
  assign pop = out_if.valid && out_if.ready;
  assign out_if.valid = fill_q != '0;
  assign out_if.data  = fifo_q[rp_q];
  always_ff @(posedge clk_i) begin
    if (rv) fifo_q[wp_q] <= '{distance: DistWidth'(root), row_index: rt.row,
                              col_index: rt.col, last_of_run: rt.last};
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; fill_q <= '0;
    end else begin
      if (rv)  wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      fill_q <= fill_q + (FW+1)'(rv) - (FW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (FW+1)'(FifoDepth)) else $error("result buffer overflow");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !acc) else $error("point taken mid-run");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && col_q + 1'b1 == row_q) |=> !busy_q) else $error("run did not end");
endmodule

// ----- tb/sv/pairwise_euclidean_distance_unit_tb.sv -----
// Testbench for pairwise_euclidean_distance_unit. It streams points, predicts every
// lower-triangle distance and checks each result in order.
// Depends on ped_pkg, ped_stream_if and the unit itself.
module pairwise_euclidean_distance_unit_tb;
  import ped_pkg::*;

  localparam int unsigned NumPts   = 64;
  localparam int unsigned NumDims  = 8;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned StallMax = 9;
  localparam int unsigned Drain    = 60;
  localparam int unsigned WdLimit  = 20000;

  typedef logic [NumDims*CoordW-1:0] point_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxWidth-1:0] cfg_index_i;
  logic [CfgWidth-1:0]    cfg_wdata_i;

  ped_stream_if #(.T(point_t))  in_if ();
  ped_stream_if #(.T(result_t)) out_if ();

  pairwise_euclidean_distance_unit #(
    .MaxPoints (NumPts),
    .MaxDims   (NumDims),
    .CoordWidth(CoordW)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // predictor state
  logic signed [CoordW-1:0] stored_pts [NumPts][NumDims];
  int unsigned   slot_count;
  logic [6:0]    set_size;
  logic [3:0]    dims_used;

  point_t  pending_pts[$];
  result_t dist_expect_q[$];
  int      errors;
  int      points_sent;
  int      dists_seen;
  bit      idle_on;
  bit      hold_send;
  int      send_wait;
  int      recv_wait;
  int      quiet_cycles;

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b   = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x   = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic predict_distances(input point_t pt);
    int unsigned row;
    int unsigned dims;
    int unsigned lim;
    logic [63:0] sum;
    longint      diff;
    result_t     r;
    row  = slot_count % NumPts;
    dims = (dims_used > NumDims) ? NumDims : dims_used;
    for (int d = 0; d < NumDims; d++) stored_pts[row][d] = pt[d*CoordW +: CoordW];
    for (int j = 0; j < row; j++) begin
      sum = '0;
      for (int d = 0; d < dims; d++) begin
        diff = longint'(stored_pts[row][d]) - longint'(stored_pts[j][d]);
        if (diff < 0) diff = -diff;
        sum += 64'(diff * diff);
      end
      r.distance    = DistWidth'(int_sqrt(sum));
      r.row_index   = IdxWidth'(row);
      r.col_index   = IdxWidth'(j);
      r.last_of_run = (j + 1 == row);
      dist_expect_q.push_back(r);
    end
    lim = (set_size > NumPts) ? NumPts : set_size;
    slot_count = (row + 1 >= lim) ? 0 : (row + 1) % NumPts;
  endtask

  function automatic point_t rand_point();
    point_t p;
    for (int d = 0; d < NumDims; d++) begin
      case ($urandom_range(0, 3))
        0: p[d*CoordW +: CoordW] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        1: p[d*CoordW +: CoordW] = CoordW'($urandom_range(0, 1023)) - 16'd512;
        default: p[d*CoordW +: CoordW] = CoordW'($urandom());
      endcase
    end
    return p;
  endfunction

  function automatic point_t fill_point(input logic [CoordW-1:0] v);
    point_t p;
    for (int d = 0; d < NumDims; d++) p[d*CoordW +: CoordW] = v;
    return p;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sender: one transfer per point, random gap after each while idle_on is set
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
      send_wait   <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_distances(in_if.data);
        points_sent++;
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (send_wait > 0) begin
          send_wait   <= send_wait - 1;
          in_if.valid <= 1'b0;
        end else if (pending_pts.size() > 0 && !hold_send) begin
          in_if.data  <= pending_pts.pop_front();
          in_if.valid <= 1'b1;
          send_wait   <= idle_on ? $urandom_range(0, StallMax) : 0;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result, stalls at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_wait    <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        dists_seen++;
        if (dist_expect_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_if.data);
          errors++;
        end else begin
          result_t e;
          e = dist_expect_q.pop_front();
          if (e.distance !== out_if.data.distance) begin
            $display("%0t: distance exp %0d got %0d", $time, e.distance, out_if.data.distance);
            errors++;
          end
          if (e.row_index !== out_if.data.row_index) begin
            $display("%0t: row exp %0d got %0d", $time, e.row_index, out_if.data.row_index);
            errors++;
          end
          if (e.col_index !== out_if.data.col_index) begin
            $display("%0t: col exp %0d got %0d", $time, e.col_index, out_if.data.col_index);
            errors++;
          end
          if (e.last_of_run !== out_if.data.last_of_run) begin
            $display("%0t: last exp %0b got %0b", $time, e.last_of_run,
                     out_if.data.last_of_run);
            errors++;
          end
        end
      end
      if (recv_wait > 0) begin
        recv_wait    <= recv_wait - 1;
        out_if.ready <= 1'b0;
      end else if (out_if.valid && out_if.ready && idle_on) begin
        recv_wait    <= $urandom_range(0, StallMax);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WdLimit) begin
      $display("watchdog expired");
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // settle, then re-check after the drain wait, so a point launched at the last check is not missed
  task automatic drain_all();
    do begin
      while (pending_pts.size() > 0 || in_if.valid || dist_expect_q.size() > 0)
        @(posedge clk_i);
      repeat (Drain) @(posedge clk_i);
    end while (pending_pts.size() > 0 || in_if.valid || dist_expect_q.size() > 0);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input int unsigned val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= CfgWidth'(val);
    @(posedge clk_i);
    if (idx == RegNumPoints) set_size = CfgWidth'(val);
    else dims_used = 4'(val);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned pts, input int unsigned dims, input int n);
    drain_all();
    @(posedge clk_i);
    write_reg(RegNumPoints, pts);
    write_reg(RegNumDims, dims);
    @(posedge clk_i);
    for (int i = 0; i < n; i++) pending_pts.push_back(rand_point());
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_wdata_i  = '0;
    errors       = 0;
    points_sent  = 0;
    dists_seen   = 0;
    idle_on      = 1'b1;
    hold_send    = 1'b0;
    quiet_cycles = 0;
    slot_count   = 0;
    set_size     = 7'd64;
    dims_used    = 4'd2;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset settings: coordinate extremes and bit patterns
    pending_pts.push_back(fill_point(16'h8000));
    pending_pts.push_back(fill_point(16'h7fff));
    pending_pts.push_back(fill_point(16'h0000));
    pending_pts.push_back(fill_point(16'h5555));
    pending_pts.push_back(fill_point(16'haaaa));
    pending_pts.push_back(fill_point(16'hffff));
    pending_pts.push_back(fill_point(16'h0001));
    // full dimensions, three-point sets, largest distances
    drain_all();
    write_reg(RegNumPoints, 3);
    write_reg(RegNumDims, 8);
    pending_pts.push_back(fill_point(16'h8000));
    pending_pts.push_back(fill_point(16'h7fff));
    pending_pts.push_back(fill_point(16'h0000));
    pending_pts.push_back(fill_point(16'h7fff));
    // degenerate set sizes and dimension counts
    run_phase(1, 0, 3);
    run_phase(0, 15, 3);
    run_phase(4, 0, 5);
    // sender held back mid-stream until every result is in: pressure point
    run_phase(127, 15, 70);
    while (pending_pts.size() > 35) @(posedge clk_i);
    hold_send = 1'b1;
    while (in_if.valid || dist_expect_q.size() > 0) @(posedge clk_i);
    hold_send = 1'b0;
    drain_all();
    run_phase(64, 8, 0);
    // shrink the set mid-way: counter is past the new size
    run_phase(5, 3, 8);
    idle_on = 1'b0;
    run_phase(2, 1, 12);
    idle_on = 1'b1;
    for (int k = 0; k < 6; k++)
      run_phase($urandom_range(2, 16), $urandom_range(0, 15), 15);
    drain_all();

    if (dist_expect_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, dist_expect_q.size());
      errors++;
    end
    $display("Sent %0d points over several set sizes and dimension counts;", points_sent);
    $display("checked %0d distances, %0d errors.", dists_seen, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
